// ===== rtl/cfa_pkg.sv =====
package cfa_pkg;

	localparam int MAX_FRAMES_DEF = 1024;
	localparam int NW = 11;   // width of frame counts and the pool size
	localparam int FW = 20;   // width of absolute frame numbers

	// frame states
	localparam logic [1:0] ST_FREE = 2'b00;
	localparam logic [1:0] ST_USED = 2'b01;
	localparam logic [1:0] ST_HEAD = 2'b11;

	// request modes
	localparam logic [1:0] MD_INIT = 2'd0;
	localparam logic [1:0] MD_ALLOC = 2'd1;
	localparam logic [1:0] MD_REL = 2'd2;
	localparam logic [1:0] MD_MARK = 2'd3;

	// result codes
	localparam logic [2:0] RS_OK = 3'd0;
	localparam logic [2:0] RS_TOO_FEW = 3'd1;
	localparam logic [2:0] RS_NO_RUN = 3'd2;
	localparam logic [2:0] RS_RANGE = 3'd3;
	localparam logic [2:0] RS_NOT_HEAD = 3'd4;
	localparam logic [2:0] RS_NOT_POOL = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_BASE = 2'd0;
	localparam logic [1:0] CFG_POOL = 2'd1;
	localparam logic [1:0] CFG_RSV = 2'd2;

	typedef struct packed {
		logic accept; // latch the incoming request
		logic ld;     // load pointers for the latched request
		logic clr;    // clearing pass after reset
		logic init;   // init sweep
		logic rd;     // issue map reads
		logic ascan;  // allocate scan
		logic awr;    // allocate write-back
		logic rwalk;  // release walk
		logic mwalk;  // mark walk
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic too_few;
		logic zero_cnt;
		logic rel_bad;
		logic mark_bad;
		logic hit;
		logic scan_last;
		logic not_head;
		logic rel_stop;
		logic awr_last;
		logic init_last;
	} flags_t;

endpackage

// ===== rtl/contiguous_frame_allocator.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    mode, frame_number, frame_count
// out       output     out_valid / out_ready  status
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time; a result register lets the next request in while it waits.
// Init writes every frame of the map, one map write a cycle. Allocate scans one frame
// a cycle (the whole pool when no run fits), then writes one claimed frame a cycle.
// Release and mark walk one frame a cycle. Checks that fail answer without a map walk.
// After reset a clearing pass over the whole map runs before the first request.
// Stalls on out hold the finished result and block the next result, and with it in_ready.
module contiguous_frame_allocator #(
	parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [cfa_pkg::FW-1:0] frame_number,
	input  logic [cfa_pkg::NW-1:0] frame_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [cfa_pkg::FW-1:0] cfg_data
);

	logic [cfa_pkg::FW-1:0] base_frame_q;
	logic [cfa_pkg::NW-1:0] pool_frames_q;
	logic                   reserve_first_q;
	cfa_pkg::cmd_t          cmd;
	cfa_pkg::flags_t        flags;

	// config writes are always taken; an index beyond the list is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= '0;
			pool_frames_q <= cfa_pkg::NW'(1024);
			reserve_first_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfa_pkg::CFG_BASE: base_frame_q <= cfg_data;
				cfa_pkg::CFG_POOL: pool_frames_q <= cfg_data[cfa_pkg::NW-1:0];
				cfa_pkg::CFG_RSV: reserve_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequence the request phases
	cfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.flags     (flags),
		.cmd       (cmd)
	);

	// hold the frame map, the free count and the walk pointers
	cfa_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.frame_number  (frame_number),
		.frame_count   (frame_count),
		.base_frame    (base_frame_q),
		.pool_frames   (pool_frames_q),
		.reserve_first (reserve_first_q),
		.flags         (flags)
	);

endmodule

// ===== rtl/cfa_datapath.sv =====
module cfa_datapath #(
	parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfa_pkg::cmd_t           cmd,
	input  logic [1:0]              mode,
	input  logic [cfa_pkg::FW-1:0]  frame_number,
	input  logic [cfa_pkg::NW-1:0]  frame_count,
	input  logic [cfa_pkg::FW-1:0]  base_frame,
	input  logic [cfa_pkg::NW-1:0]  pool_frames,
	input  logic                    reserve_first,
	output cfa_pkg::flags_t         flags
);

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int PW = (AW + 1 > 12) ? AW + 1 : 12;
	localparam int NRST = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;
	localparam int NW = cfa_pkg::NW;
	localparam int FW = cfa_pkg::FW;

	logic [1:0]    mem [MAX_FRAMES];
	logic [1:0]    rd_q;
	logic [1:0]    mode_q;
	logic [FW-1:0] frame_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] fc_q;
	logic [NW-1:0] run_q;
	logic [PW-1:0] ptr_q, end_q, start_q, idx_s1;
	logic          vld_s1;

	logic [NW-1:0] n;
	logic [PW-1:0] n_p, cnt_p, rel_p;
	logic          re, we, first, last, is_free, is_head, rel_wr, mark_wr;
	logic [PW-1:0] waddr;
	logic [1:0]    wdata;

	assign n = (32'(pool_frames) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : pool_frames;
	assign n_p = {{(PW-NW){1'b0}}, n};
	assign cnt_p = {{(PW-NW){1'b0}}, cnt_q};
	assign rel_p = PW'(frame_q - base_frame);

	assign re = cmd.rd && (ptr_q < end_q);
	assign first = idx_s1 == start_q;
	assign last = idx_s1 == end_q - PW'(1);
	assign is_free = rd_q == cfa_pkg::ST_FREE;
	assign is_head = rd_q == cfa_pkg::ST_HEAD;
	assign rel_wr = cmd.rwalk && vld_s1 && (first ? is_head : !(is_free || is_head));
	assign mark_wr = cmd.mwalk && vld_s1 && is_free;

	always_comb begin
		flags.mode = mode_q;
		flags.too_few = (cnt_q > fc_q) || (cnt_q > n);
		flags.zero_cnt = cnt_q == '0;
		flags.rel_bad = (frame_q < base_frame) ||
			({1'b0, frame_q} >= {1'b0, base_frame} + {{(FW+1-NW){1'b0}}, n});
		flags.mark_bad = (frame_q < base_frame) ||
			({2'b0, frame_q} + {{(FW+2-NW){1'b0}}, cnt_q} >
			 {2'b0, base_frame} + {{(FW+2-NW){1'b0}}, n});
		flags.hit = cmd.ascan && vld_s1 && is_free && (run_q + NW'(1) == cnt_q);
		flags.scan_last = vld_s1 && last;
		flags.not_head = cmd.rwalk && vld_s1 && first && !is_head;
		flags.rel_stop = cmd.rwalk && vld_s1 && ((!first && (is_free || is_head)) || last);
		flags.awr_last = ptr_q == start_q + cnt_p - PW'(1);
		flags.init_last = ptr_q == PW'(MAX_FRAMES - 1);
	end

	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = cfa_pkg::ST_FREE;
		if (cmd.init) begin
			we = 1'b1;
			if (ptr_q == '0 && (cmd.clr || (reserve_first && n != '0)))
				wdata = cfa_pkg::ST_USED;
		end else if (cmd.awr) begin
			we = 1'b1;
			wdata = (ptr_q == start_q) ? cfa_pkg::ST_HEAD : cfa_pkg::ST_USED;
		end else if (rel_wr) begin
			we = 1'b1;
			waddr = idx_s1;
		end else if (mark_wr) begin
			we = 1'b1;
			waddr = idx_s1;
			wdata = first ? cfa_pkg::ST_HEAD : cfa_pkg::ST_USED;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr[AW-1:0]] <= wdata;
		if (re)
			rd_q <= mem[ptr_q[AW-1:0]];
		idx_s1 <= ptr_q;
		if (cmd.accept) begin
			mode_q <= mode;
			frame_q <= frame_number;
			cnt_q <= frame_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			end_q <= '0;
			start_q <= '0;
			run_q <= '0;
			vld_s1 <= 1'b0;
			fc_q <= NW'(NRST - 1);
		end else begin
			vld_s1 <= re;
			if (cmd.ld) begin
				run_q <= '0;
				start_q <= rel_p;
				case (mode_q)
					cfa_pkg::MD_INIT: begin
						ptr_q <= '0;
						fc_q <= (reserve_first && n != '0) ? n - NW'(1) : n;
					end
					cfa_pkg::MD_ALLOC: begin
						ptr_q <= '0;
						end_q <= n_p;
					end
					cfa_pkg::MD_REL: begin
						ptr_q <= rel_p;
						end_q <= n_p;
					end
					default: begin
						ptr_q <= rel_p;
						end_q <= rel_p + cnt_p;
					end
				endcase
			end else if (flags.hit) begin
				ptr_q <= (run_q == '0) ? idx_s1 : start_q;
				fc_q <= fc_q - cnt_q;
			end else if (cmd.init || cmd.awr || re) begin
				ptr_q <= ptr_q + PW'(1);
			end
			if (cmd.ascan && vld_s1) begin
				if (is_free) begin
					if (run_q == '0)
						start_q <= idx_s1;
					run_q <= run_q + NW'(1);
				end else begin
					run_q <= '0;
				end
			end
			if (rel_wr && fc_q != '1)
				fc_q <= fc_q + NW'(1);
			if (mark_wr && fc_q != '0)
				fc_q <= fc_q - NW'(1);
		end
	end

endmodule

// ===== rtl/cfa_ctrl.sv =====
module cfa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	input  cfa_pkg::flags_t flags,
	output cfa_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_INIT = 3'd2;
	localparam logic [2:0] S_ASCAN = 3'd3;
	localparam logic [2:0] S_AWR = 3'd4;
	localparam logic [2:0] S_RWALK = 3'd5;
	localparam logic [2:0] S_MWALK = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       clr_q, out_valid_q;
	logic [2:0] status_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign status = status_q;

	always_comb begin
		cmd = '0;
		cmd.accept = in_valid && in_ready;
		cmd.ld = state_q == S_DEC;
		cmd.clr = clr_q;
		cmd.init = state_q == S_INIT;
		cmd.ascan = state_q == S_ASCAN;
		cmd.awr = state_q == S_AWR;
		cmd.rwalk = state_q == S_RWALK;
		cmd.mwalk = state_q == S_MWALK;
		cmd.rd = cmd.ascan || cmd.rwalk || cmd.mwalk;
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		case (state_q)
			S_IDLE: if (cmd.accept) state_d = S_DEC;
			S_DEC: begin
				state_d = S_DONE;
				st_d = cfa_pkg::RS_OK;
				case (flags.mode)
					cfa_pkg::MD_INIT: state_d = S_INIT;
					cfa_pkg::MD_ALLOC: begin
						if (flags.too_few) st_d = cfa_pkg::RS_TOO_FEW;
						else if (flags.zero_cnt) st_d = cfa_pkg::RS_NO_RUN;
						else state_d = S_ASCAN;
					end
					cfa_pkg::MD_REL: begin
						if (flags.rel_bad) st_d = cfa_pkg::RS_NOT_POOL;
						else state_d = S_RWALK;
					end
					default: begin
						if (flags.mark_bad) st_d = cfa_pkg::RS_RANGE;
						else if (!flags.zero_cnt) state_d = S_MWALK;
					end
				endcase
			end
			S_INIT: begin
				if (flags.init_last) begin
					state_d = clr_q ? S_IDLE : S_DONE;
					st_d = cfa_pkg::RS_OK;
				end
			end
			S_ASCAN: begin
				if (flags.hit) state_d = S_AWR;
				else if (flags.scan_last) begin
					state_d = S_DONE;
					st_d = cfa_pkg::RS_NO_RUN;
				end
			end
			S_AWR: begin
				if (flags.awr_last) begin
					state_d = S_DONE;
					st_d = cfa_pkg::RS_OK;
				end
			end
			S_RWALK: begin
				if (flags.not_head) begin
					state_d = S_DONE;
					st_d = cfa_pkg::RS_NOT_HEAD;
				end else if (flags.rel_stop) begin
					state_d = S_DONE;
					st_d = cfa_pkg::RS_OK;
				end
			end
			S_MWALK: begin
				if (flags.scan_last) begin
					state_d = S_DONE;
					st_d = cfa_pkg::RS_OK;
				end
			end
			S_DONE: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q <= 1'b1;
			st_q <= cfa_pkg::RS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			if (state_q == S_INIT && flags.init_last)
				clr_q <= 1'b0;
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready))
			status_q <= st_q;
	end

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init, cmd.ascan, cmd.awr, cmd.rwalk, cmd.mwalk}))
		else $error("more than one datapath phase active");
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DEC)
		else $error("accepted request not decoded");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("finished result not presented");
	a_clr_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready)
		else $error("request taken during clearing pass");

endmodule

// ===== tb/sv/contiguous_frame_allocator_test.sv =====
`timescale 1ns / 1ps

module contiguous_frame_allocator_test;
	import cfa_pkg::*;

	localparam int MAXF = MAX_FRAMES_DEF;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      mode;
	logic [FW-1:0]   frame_number;
	logic [NW-1:0]   frame_count;
	logic            out_valid;
	logic            out_ready;
	logic [2:0]      status;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [1:0]      cfg_index;
	logic [FW-1:0]   cfg_data;

	contiguous_frame_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .frame_number(frame_number), .frame_count(frame_count),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the allocator: frame states, free count and registers
	logic [1:0] shadow_map [MAXF];
	int         shadow_free;
	int         shadow_base;
	int         shadow_pool;
	int         shadow_rsv;

	// Statuses still owed by the block, oldest first
	logic [2:0] status_due [$];

	int  mismatches;
	int  requests_sent;
	int  results_seen;
	bit  calm;       // no idling on either side while set
	bit  sender_done;

	typedef struct {
		logic [1:0]    md;
		logic [FW-1:0] frm;
		logic [NW-1:0] cnt;
		bit            known;
		logic [2:0]    st;
	} dir_row_t;

	typedef struct {
		int base;
		int pool;
		int rsv;
		bit reinit;
		int items;
	} phase_t;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pool_in_use();
		return (shadow_pool > MAXF) ? MAXF : shadow_pool;
	endfunction

	function automatic void shadow_init();
		int n;
		n = pool_in_use();
		for (int i = 0; i < MAXF; i++) shadow_map[i] = ST_FREE;
		shadow_free = n;
		if (shadow_rsv != 0 && n > 0) begin
			shadow_map[0] = ST_USED;
			shadow_free = n - 1;
		end
	endfunction

	// Advance the shadow by one request and return the status it must give
	function automatic logic [2:0] allocator_outcome(logic [1:0] md, int frm, int cnt);
		int n, start, run, rel;
		n = pool_in_use();
		case (md)
			MD_INIT: begin
				shadow_init();
				return RS_OK;
			end
			MD_ALLOC: begin
				if (cnt > shadow_free || cnt > n) return RS_TOO_FEW;
				start = 0;
				run = 0;
				for (int i = 0; i < n; i++) begin
					if (shadow_map[i] == ST_FREE) begin
						if (run == 0) start = i;
						run++;
						if (run == cnt) break;
					end else begin
						run = 0;
					end
				end
				if (cnt == 0 || run != cnt) return RS_NO_RUN;
				shadow_map[start] = ST_HEAD;
				for (int i = start + 1; i < start + cnt; i++) shadow_map[i] = ST_USED;
				shadow_free -= cnt;
				return RS_OK;
			end
			MD_REL: begin
				if (frm < shadow_base || frm >= shadow_base + n) return RS_NOT_POOL;
				rel = frm - shadow_base;
				if (shadow_map[rel] != ST_HEAD) return RS_NOT_HEAD;
				shadow_map[rel] = ST_FREE;
				if (shadow_free < 2047) shadow_free++;
				for (int i = rel + 1; i < n; i++) begin
					if (shadow_map[i] == ST_FREE || shadow_map[i] == ST_HEAD) break;
					shadow_map[i] = ST_FREE;
					if (shadow_free < 2047) shadow_free++;
				end
				return RS_OK;
			end
			default: begin
				if (frm < shadow_base || frm + cnt > shadow_base + n) return RS_RANGE;
				rel = frm - shadow_base;
				for (int i = 0; i < cnt; i++) begin
					if (shadow_map[rel + i] == ST_FREE) begin
						shadow_map[rel + i] = (i == 0) ? ST_HEAD : ST_USED;
						if (shadow_free > 0) shadow_free--;
					end
				end
				return RS_OK;
			end
		endcase
	endfunction

	// Offer one request; record its status once the block takes it
	task automatic send_request(logic [1:0] md, logic [FW-1:0] frm, logic [NW-1:0] cnt,
			bit known, logic [2:0] st);
		logic [2:0] due;
		while (!calm && $urandom_range(0, 99) < 23) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = md;
		frame_number = frm;
		frame_count = cnt;
		do @(posedge clk); while (!in_ready);
		due = allocator_outcome(md, int'(frm), int'(cnt));
		// typed expectations stand in for the shadow's answer on those rows
		status_due.push_back(known ? st : due);
		requests_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [FW-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BASE: shadow_base = int'(val);
			CFG_POOL: shadow_pool = int'(val[NW-1:0]);
			CFG_RSV:  shadow_rsv = int'(val[0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait for the block to drain before touching its registers
	task automatic wait_drained();
		while (status_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Pick a head inside the pool if one exists, else any pool frame
	function automatic int pick_head(int n);
		int s;
		if (n == 0) return 0;
		s = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++)
			if (shadow_map[(s + i) % n] == ST_HEAD) return (s + i) % n;
		return s;
	endfunction

	task automatic random_request();
		int n, r, rel, cnt;
		n = pool_in_use();
		r = $urandom_range(0, 99);
		if (r < 32) begin
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n + 2)
				: $urandom_range(1, (n / 4 > 1) ? n / 4 : 1);
			send_request(MD_ALLOC, FW'($urandom), cnt[NW-1:0], 1'b0, RS_OK);
		end else if (r < 58) begin
			rel = pick_head(n);
			send_request(MD_REL, FW'(shadow_base + rel), NW'($urandom), 1'b0, RS_OK);
		end else if (r < 74) begin
			rel = (n > 0) ? $urandom_range(0, n - 1) : 0;
			cnt = $urandom_range(0, (n - rel < 12) ? n - rel : 12);
			send_request(MD_MARK, FW'(shadow_base + rel), cnt[NW-1:0], 1'b0, RS_OK);
		end else if (r < 78) begin
			send_request(MD_INIT, FW'($urandom), NW'($urandom), 1'b0, RS_OK);
		end else begin
			// noise: every field at random, full width
			send_request(2'($urandom), FW'($urandom), NW'($urandom), 1'b0, RS_OK);
		end
	endtask

	// Sender: directed rows, then phases of random traffic
	initial begin
		dir_row_t rows [21];
		phase_t   phases [9];
		in_valid = 1'b0;
		mode = MD_INIT;
		frame_number = '0;
		frame_count = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		sender_done = 1'b0;
		mismatches = 0;
		requests_sent = 0;
		results_seen = 0;
		shadow_base = 0;
		shadow_pool = 1024;
		shadow_rsv = 1;
		shadow_init();

		rows = '{
			'{MD_ALLOC, 20'd0,       11'd0,    1'b1, RS_NO_RUN},
			'{MD_ALLOC, 20'd0,       11'd1025, 1'b1, RS_TOO_FEW},
			'{MD_ALLOC, 20'd0,       11'd1024, 1'b1, RS_TOO_FEW},
			'{MD_REL,   20'd1024,    11'd0,    1'b1, RS_NOT_POOL},
			'{MD_REL,   20'd0,       11'd0,    1'b1, RS_NOT_HEAD},
			'{MD_MARK,  20'd1020,    11'd5,    1'b1, RS_RANGE},
			'{MD_MARK,  20'd0,       11'd0,    1'b1, RS_OK},
			'{MD_REL,   20'hFFFFF,   11'h7FF,  1'b1, RS_NOT_POOL},
			'{MD_ALLOC, 20'd0,       11'd1023, 1'b1, RS_OK},
			'{MD_ALLOC, 20'd0,       11'd1,    1'b1, RS_TOO_FEW},
			'{MD_REL,   20'd1,       11'd0,    1'b1, RS_OK},
			'{MD_REL,   20'd2,       11'd0,    1'b1, RS_NOT_HEAD},
			'{MD_INIT,  20'hFFFFF,   11'h7FF,  1'b1, RS_OK},
			'{MD_ALLOC, 20'd0,       11'd4,    1'b0, RS_OK},
			'{MD_ALLOC, 20'd0,       11'h7FF,  1'b1, RS_TOO_FEW},
			'{MD_MARK,  20'd2,       11'd6,    1'b0, RS_OK},
			'{MD_REL,   20'd2,       11'd0,    1'b0, RS_OK},
			'{MD_MARK,  20'd1023,    11'd1,    1'b0, RS_OK},
			'{MD_REL,   20'd1023,    11'd0,    1'b0, RS_OK},
			'{MD_MARK,  20'd0,       11'd1024, 1'b0, RS_OK},
			'{MD_INIT,  20'd0,       11'd0,    1'b1, RS_OK}
		};
		// base, pool, reserve, init first, items
		phases = '{
			'{0,       8,    1, 1'b1, 70},
			'{12345,   64,   0, 1'b1, 70},
			'{1048575, 16,   1, 1'b1, 60},
			'{777,     13,   0, 1'b1, 60},
			'{777,     40,   0, 1'b0, 50},
			'{0,       0,    1, 1'b1, 30},
			'{1048568, 8,    0, 1'b1, 60},
			'{500,     2047, 0, 1'b1, 70},
			'{0,       1024, 1, 1'b1, 90}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_request(rows[i].md, rows[i].frm, rows[i].cnt, rows[i].known, rows[i].st);

		foreach (phases[p]) begin
			wait_drained();
			write_reg(CFG_BASE, FW'(phases[p].base));
			write_reg(CFG_POOL, FW'(phases[p].pool));
			write_reg(CFG_RSV, FW'(phases[p].rsv));
			if (phases[p].reinit) send_request(MD_INIT, '0, '0, 1'b0, RS_OK);
			for (int k = 0; k < phases[p].items; k++) begin
				// hold a stretch with no idling in the middle of the run
				calm = (requests_sent >= 260 && requests_sent < 340);
				random_request();
			end
		end
		calm = 1'b0;
		sender_done = 1'b1;
	end

	// Receiver: random back-pressure, one long hold-off, check every result
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen == 120) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = calm || ($urandom_range(0, 99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d", status);
			end else begin
				if (status !== status_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status mismatch on result %0d: expected %0d, got %0d",
							results_seen, status_due[0], status);
				end
				void'(status_due.pop_front());
			end
		end
	end

	// Finish once the sender is done and nothing is owed
	initial begin
		wait (sender_done);
		while (status_due.size() != 0) @(posedge clk);
		repeat (2100) @(posedge clk);
		if (mismatches == 0 && status_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
